@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the sorted list queue RTL.
// Included by bare file name; it depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising clock edge outside reset.
`define SLQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sorted list queue check failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define SLQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sorted list queue implication failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define SLQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sorted list queue next-cycle check failed");

`else

`define SLQ_ASSERT(lbl, clk, rstn, prop)
`define SLQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SLQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/slq_pkg.sv @@
// Shared types and constants of the sorted list queue.
// Used by slq_cell, sorted_list_queue and the testbench; it depends on nothing else.
`default_nettype none

package slq_pkg;

  // Field widths fixed by the word format.
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_FULL       = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_EMPTY_POP  = STATUS_W'(2);

  // Control broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic                    en;
    logic                    remove;
    logic signed [VAL_W-1:0] value;
  } slq_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/slq_cell.sv @@
// One cell of the sorted row: holds a single entry and trades it with its neighbors.
// Depends on slq_pkg for the control struct and the value width.
`default_nettype none

module slq_cell (
  input  wire logic                            clk_i,
  input  wire slq_pkg::slq_ctrl_t              ctrl_i,
  input  wire logic                            occ_i,
  input  wire logic                            left_occ_i,
  input  wire logic                            left_gt_i,
  input  wire logic signed [slq_pkg::VAL_W-1:0] left_entry_i,
  input  wire logic signed [slq_pkg::VAL_W-1:0] right_entry_i,
  output logic                                 gt_o,
  output logic signed [slq_pkg::VAL_W-1:0]     entry_o
);

  logic signed [slq_pkg::VAL_W-1:0] entry_q;
  logic signed [slq_pkg::VAL_W-1:0] entry_d;

  // An occupied entry above the new value has to move up one place.
  assign gt_o    = occ_i && (entry_q > ctrl_i.value);
  assign entry_o = entry_q;

  // Next entry: shift down on removal; on insertion take the left neighbor,
  // the new value, or keep the current entry.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.en) begin
      if (ctrl_i.remove) begin
        entry_d = right_entry_i;
      end else if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o || (!occ_i && left_occ_i)) begin
        entry_d = ctrl_i.value;
      end
    end
  end

  // The entry is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_list_queue.sv @@
// Sorted list queue: each accepted word gives its result word in the next cycle.
// Throughput is one word per cycle unless the output stalls; every entry of the row
// updates in that cycle. The result sits in an output register, so a new word is taken
// whenever that register is empty or is being read in the same cycle.
// Reset clears the count and the output valid; the stored entries are not cleared.
// Depends on slq_pkg, slq_cell and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sorted_list_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                operation_i,
  input  wire logic signed [slq_pkg::VAL_W-1:0]    value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [slq_pkg::VAL_W-1:0]         smallest_o,
  output logic signed [slq_pkg::VAL_W-1:0]         largest_o,
  output logic [slq_pkg::COUNT_W-1:0]              count_o,
  output logic                                     empty_res_o,
  output logic [slq_pkg::STATUS_W-1:0]             status_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                                 accept;
  logic                                 full;
  logic                                 empty;
  logic [slq_pkg::STATUS_W-1:0]         status;
  slq_pkg::slq_ctrl_t                   ctrl;

  logic [CNT_W-1:0]                     cnt_q;
  logic [CNT_W-1:0]                     cnt_d;
  logic signed [slq_pkg::VAL_W-1:0]     largest_q;
  logic signed [slq_pkg::VAL_W-1:0]     largest_d;
  logic [CNT_W+slq_pkg::COUNT_W-1:0]    cnt_ext;

  logic                                 out_valid_q;
  logic signed [slq_pkg::VAL_W-1:0]     res_smallest_q;
  logic signed [slq_pkg::VAL_W-1:0]     res_largest_q;
  logic [slq_pkg::COUNT_W-1:0]          res_count_q;
  logic                                 res_empty_q;
  logic [slq_pkg::STATUS_W-1:0]         res_status_q;

  logic [DEPTH-1:0]                     occ;
  logic [DEPTH-1:0]                     gt;
  logic signed [slq_pkg::VAL_W-1:0]     ent [DEPTH];
  logic signed [slq_pkg::VAL_W-1:0]     ent_d0;

  // A word is taken whenever the result register is free or drains this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (cnt_q == CNT_W'(DEPTH));
  assign empty = (cnt_q == '0);

  // Status of the current word and the control sent along the row.
  always_comb begin
    status = slq_pkg::ST_OK;
    if (operation_i == slq_pkg::OP_INSERT && full) begin
      status = slq_pkg::ST_FULL;
    end else if (operation_i == slq_pkg::OP_REMOVE && empty) begin
      status = slq_pkg::ST_EMPTY_POP;
    end
    ctrl.en     = accept && (status == slq_pkg::ST_OK);
    ctrl.remove = (operation_i == slq_pkg::OP_REMOVE);
    ctrl.value  = value_i;
  end

  // Count and tracked largest entry.
  always_comb begin
    cnt_d     = cnt_q;
    largest_d = largest_q;
    if (ctrl.en) begin
      if (ctrl.remove) begin
        cnt_d = cnt_q - CNT_W'(1);
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
        if (empty || (value_i >= largest_q)) begin
          largest_d = value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    largest_q <= largest_d;
  end

  // Row of cells; each cell learns whether its place is occupied.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                             left_occ;
    logic                             left_gt;
    logic signed [slq_pkg::VAL_W-1:0] left_entry;
    logic signed [slq_pkg::VAL_W-1:0] right_entry;

    assign occ[g] = (cnt_q > CNT_W'(g));

    if (g == 0) begin : g_first
      assign left_occ   = 1'b1;
      assign left_gt    = 1'b0;
      assign left_entry = value_i;
    end else begin : g_inner
      assign left_occ   = occ[g-1];
      assign left_gt    = gt[g-1];
      assign left_entry = ent[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_entry = ent[g];
    end else begin : g_mid
      assign right_entry = ent[g+1];
    end

    slq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ[g]),
      .left_occ_i   (left_occ),
      .left_gt_i    (left_gt),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .gt_o         (gt[g]),
      .entry_o      (ent[g])
    );
  end

  // New first entry, as the first cell will hold it after this word.
  always_comb begin
    ent_d0 = ent[0];
    if (ctrl.en) begin
      if (ctrl.remove) begin
        ent_d0 = ent[1];
      end else if (empty || (value_i < ent[0])) begin
        ent_d0 = value_i;
      end
    end
  end

  // The count field carries the low bits of the count after this word.
  assign cnt_ext = {{slq_pkg::COUNT_W{1'b0}}, cnt_d};

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_smallest_q <= (cnt_d == '0) ? '0 : ent_d0;
      res_largest_q  <= (cnt_d == '0) ? '0 : largest_d;
      res_count_q    <= cnt_ext[slq_pkg::COUNT_W-1:0];
      res_empty_q    <= (cnt_d == '0);
      res_status_q   <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign smallest_o  = res_smallest_q;
  assign largest_o   = res_largest_q;
  assign count_o     = res_count_q;
  assign empty_res_o = res_empty_q;
  assign status_o    = res_status_q;

  // The count never passes the capacity of the row.
  `SLQ_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH))

  // A refused word leaves the count as it was.
  `SLQ_ASSERT_NEXT(a_refused_hold, clk_i, rst_ni,
                   accept && (status != slq_pkg::ST_OK), cnt_q == $past(cnt_q))

  // A non-empty result keeps its extremes in order.
  `SLQ_ASSERT_IMPL(a_order, clk_i, rst_ni, out_valid_q && !res_empty_q,
                   res_smallest_q <= res_largest_q)

  // A full refusal is only reported with the row full.
  `SLQ_ASSERT_IMPL(a_full_status, clk_i, rst_ni,
                   out_valid_q && (res_status_q == slq_pkg::ST_FULL), full)

endmodule

`default_nettype wire

@@ tb/sv/sorted_list_queue_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sorted_list_queue: random and directed insert/remove words
// with idle and stall bursts on both sides, checked against an in-bench sorted store.
// Depends on slq_pkg and the sorted_list_queue RTL.

module sorted_list_queue_test;

  localparam int VAL_W    = slq_pkg::VAL_W;
  localparam int COUNT_W  = slq_pkg::COUNT_W;
  localparam int STATUS_W = slq_pkg::STATUS_W;

  localparam int DEPTH        = 16;
  localparam int RANDOM_WORDS = 600;
  // Once this few words are left to send, neither side starts a new idle or stall burst.
  localparam int CALM_TAIL    = 60;

  typedef struct packed {
    logic                    op;
    logic signed [VAL_W-1:0] value;
  } slq_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] smallest;
    logic signed [VAL_W-1:0] largest;
    logic [COUNT_W-1:0]      count;
    logic                    empty_res;
    logic [STATUS_W-1:0]     status;
  } slq_summary_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    operation_i = slq_pkg::OP_INSERT;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    out_stall_i = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic signed [VAL_W-1:0] smallest_o;
  logic signed [VAL_W-1:0] largest_o;
  logic [COUNT_W-1:0]      count_o;
  logic                    empty_res_o;
  logic [STATUS_W-1:0]     status_o;

  sorted_list_queue #(.DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .smallest_o  (smallest_o),
    .largest_o   (largest_o),
    .count_o     (count_o),
    .empty_res_o (empty_res_o),
    .status_o    (status_o)
  );

  // Words waiting to be sent and summaries waiting to arrive.
  slq_word_t    words_to_send[$];
  slq_summary_t summaries_due[$];

  // Predicted contents of the queue, kept in ascending order.
  logic signed [VAL_W-1:0] sorted_vals[DEPTH];
  int unsigned             sorted_cnt = 0;

  int mismatch_count  = 0;
  int checked_count   = 0;
  int refused_inserts = 0;
  int refused_removes = 0;
  int fullest_seen    = 0;
  int send_gap        = 0;
  int stall_left      = 0;
  slq_word_t    next_word;
  slq_summary_t got_summary;

  // Apply one word to the predicted store and return the summary it should produce.
  function automatic slq_summary_t sort_and_report(input logic op,
                                                   input logic signed [VAL_W-1:0] v);
    slq_summary_t s;
    int unsigned  i;
    s.status = slq_pkg::ST_OK;
    if (op == slq_pkg::OP_INSERT) begin
      if (sorted_cnt >= DEPTH) begin
        s.status = slq_pkg::ST_FULL;
        refused_inserts++;
      end else begin
        // Larger entries move up one place; equal entries stay below the new one.
        i = sorted_cnt;
        while (i > 0 && sorted_vals[i-1] > v) begin
          sorted_vals[i] = sorted_vals[i-1];
          i--;
        end
        sorted_vals[i] = v;
        sorted_cnt++;
      end
    end else begin
      if (sorted_cnt == 0) begin
        s.status = slq_pkg::ST_EMPTY_POP;
        refused_removes++;
      end else begin
        for (i = 1; i < sorted_cnt; i++) sorted_vals[i-1] = sorted_vals[i];
        sorted_cnt--;
      end
    end
    if (sorted_cnt > fullest_seen) fullest_seen = sorted_cnt;
    if (sorted_cnt == 0) begin
      s.smallest  = '0;
      s.largest   = '0;
      s.empty_res = 1'b1;
    end else begin
      s.smallest  = sorted_vals[0];
      s.largest   = sorted_vals[sorted_cnt-1];
      s.empty_res = 1'b0;
    end
    s.count = sorted_cnt[COUNT_W-1:0];
    return s;
  endfunction

  function automatic void add_word(input logic op, input logic signed [VAL_W-1:0] v);
    slq_word_t w;
    w.op    = op;
    w.value = v;
    words_to_send.push_back(w);
  endfunction

  // Random value: a narrow range so equal entries are common, as often full-width
  // values, and now and then an extreme, zero or minus one.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) return $urandom;
    if (kind < 8) return VAL_W'(int'($urandom_range(0, 16)) - 8);
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Driver: predict each accepted word, then hold, idle or present the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        summaries_due.push_back(sort_and_report(operation_i, value_i));
      end
      if (in_valid_i && in_stall_o) begin
        // Stalled word stays on the port unchanged.
      end else if (send_gap != 0) begin
        send_gap   <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (words_to_send.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        send_gap   <= $urandom_range(0, 13);
        in_valid_i <= 1'b0;
      end else if (words_to_send.size() != 0) begin
        next_word   = words_to_send.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= next_word.op;
        value_i     <= next_word.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: stall in bursts and compare each accepted result word with the oldest summary.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (summaries_due.size() == 0) begin
          $error("result word arrived with no summary due");
          mismatch_count++;
        end else begin
          got_summary = summaries_due.pop_front();
          checked_count++;
          if (smallest_o !== got_summary.smallest) begin
            $error("smallest: expected %0d, got %0d", got_summary.smallest, smallest_o);
            mismatch_count++;
          end
          if (largest_o !== got_summary.largest) begin
            $error("largest: expected %0d, got %0d", got_summary.largest, largest_o);
            mismatch_count++;
          end
          if (count_o !== got_summary.count) begin
            $error("count: expected %0d, got %0d", got_summary.count, count_o);
            mismatch_count++;
          end
          if (empty_res_o !== got_summary.empty_res) begin
            $error("empty_res: expected %0d, got %0d", got_summary.empty_res, empty_res_o);
            mismatch_count++;
          end
          if (status_o !== got_summary.status) begin
            $error("status: expected %0d, got %0d", got_summary.status, status_o);
            mismatch_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (words_to_send.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        stall_left  <= $urandom_range(0, 13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int made;
    int seg_len;
    int insert_pct;

    // Directed: removal from an empty store, removal of the only entry, extremes,
    // duplicates, filling to the top and an insert into a full store.
    add_word(slq_pkg::OP_REMOVE, 32'shFFFF_FFFF);
    add_word(slq_pkg::OP_INSERT, 32'sd7);
    add_word(slq_pkg::OP_REMOVE, 32'sh0000_0000);
    add_word(slq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    add_word(slq_pkg::OP_INSERT, 32'sh8000_0000);
    add_word(slq_pkg::OP_INSERT, 32'sd0);
    add_word(slq_pkg::OP_INSERT, -32'sd1);
    add_word(slq_pkg::OP_INSERT, 32'sd0);
    add_word(slq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    add_word(slq_pkg::OP_INSERT, 32'sh8000_0000);
    add_word(slq_pkg::OP_INSERT, 32'sd1);
    add_word(slq_pkg::OP_INSERT, 32'sh5555_5555);
    add_word(slq_pkg::OP_INSERT, 32'shAAAA_AAAA);
    add_word(slq_pkg::OP_INSERT, -32'sd2);
    add_word(slq_pkg::OP_INSERT, 32'sd2);
    add_word(slq_pkg::OP_INSERT, 32'sd100);
    add_word(slq_pkg::OP_INSERT, -32'sd100);
    add_word(slq_pkg::OP_INSERT, 32'sd0);
    add_word(slq_pkg::OP_INSERT, 32'sd3);
    add_word(slq_pkg::OP_INSERT, 32'sd5);
    add_word(slq_pkg::OP_REMOVE, 32'sh5555_5555);
    add_word(slq_pkg::OP_REMOVE, 32'shAAAA_AAAA);
    add_word(slq_pkg::OP_REMOVE, 32'sd0);

    // Random: segments that lean toward filling, draining or balance, so the store
    // swings between empty and full many times.
    made = 0;
    while (made < RANDOM_WORDS) begin
      seg_len = $urandom_range(10, 50);
      case ($urandom_range(0, 2))
        0: insert_pct = 15;
        1: insert_pct = 50;
        default: insert_pct = 85;
      endcase
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < insert_pct) add_word(slq_pkg::OP_INSERT, pick_value());
        else add_word(slq_pkg::OP_REMOVE, $urandom);
        made++;
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    for (int n = 0; n < 200 && summaries_due.size() != 0; n++) @(posedge clk_i);
    if (summaries_due.size() != 0) begin
      $error("%0d result words never arrived", summaries_due.size());
      mismatch_count++;
    end
    // Then keep the clock running to catch any stray result word.
    repeat (4) @(posedge clk_i);

    $display("Checked %0d result words; the store reached %0d of %0d entries.",
             checked_count, fullest_seen, DEPTH);
    $display("Refused: %0d inserts into a full store, %0d removals from an empty one.",
             refused_inserts, refused_removes);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/slq_pkg.sv
hw/rtl/slq_cell.sv
hw/rtl/sorted_list_queue.sv
tb/sv/sorted_list_queue_test.sv
